// File: rtl/kce_pkg.sv
// Shared types and constants of the kernel connectivity estimate unit.
package kce_pkg;

    localparam int BW_W     = 32;
    localparam int WEIGHT_W = 48;
    localparam int SUM_W    = 64;
    localparam int RATIO_W  = 17;
    localparam int KERN_W   = 48;
    localparam int CNT_W    = 7;

    localparam logic [BW_W-1:0]    BW_RESET    = 32'h0001_0000;
    localparam logic               KTYPE_RESET = 1'b0;
    localparam logic [RATIO_W-1:0] RATIO_ONE   = 17'h1_0000;

    // Register indexes of the configuration port.
    localparam logic CFG_BANDWIDTH   = 1'b0;
    localparam logic CFG_KERNEL_TYPE = 1'b1;

    // Divide operations issued to the shared divider.
    typedef enum logic [2:0] {
        OP_Q,
        OP_BOX,
        OP_K,
        OP_TERM,
        OP_RATIO
    } div_op_t;

    typedef struct packed {
        logic    load;
        logic    start;
        div_op_t op;
        logic    mul;
        logic    emit_empty;
        logic    emit_one;
    } kce_cmd_t;

    typedef struct packed {
        logic skip;
        logic epan;
        logic div_done;
        logic last;
        logic den_zero;
        logic num_eq_den;
        logic out_busy;
    } kce_stat_t;

endpackage

// File: rtl/kce_in_if.sv
// Input channel carrying one point-pair word.
interface kce_in_if;
    logic                valid;
    logic                ready;
    logic [31:0]         radius;
    logic [31:0]         distance;
    logic                connected;
    logic signed [47:0]  weight;
    logic                last_pair;

    modport source (output valid, radius, distance, connected, weight, last_pair,
                    input ready);
    modport sink   (input valid, radius, distance, connected, weight, last_pair,
                    output ready);
endinterface

// File: rtl/kce_out_if.sv
// Output channel carrying one ratio word.
interface kce_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] ratio;
    logic        empty_sum;

    modport source (output valid, ratio, empty_sum, input ready);
    modport sink   (input valid, ratio, empty_sum, output ready);
endinterface

// File: rtl/kce_div.sv
// Restoring radix-2 divider producing one quotient bit per cycle.
module kce_div
    import kce_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] rem_init,
    input  logic [SUM_W-1:0] dividend,
    input  logic [SUM_W-1:0] divisor,
    input  logic [CNT_W-1:0] count,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    logic [SUM_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0] dvd_reg;
    logic [SUM_W-1:0] dvs_reg;
    logic [SUM_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [SUM_W:0]   trial;
    logic             fits;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[SUM_W-1]};
        fits     = trial >= {1'b0, dvs_reg};
        rem_next = fits ? SUM_W'(trial - {1'b0, dvs_reg}) : trial[SUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= count;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[SUM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/kce_datapath.sv
// Datapath: configuration, pair registers, kernel arithmetic, sums and result register.
module kce_datapath
    import kce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [BW_W-1:0]   cfg_data,
    input  logic [31:0]       radius,
    input  logic [31:0]       distance,
    input  logic              connected,
    input  logic [WEIGHT_W-1:0] weight,
    input  logic              last_pair,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [RATIO_W-1:0] ratio,
    output logic              empty_sum,
    input  kce_cmd_t          cmd,
    output kce_stat_t         stat
);

    logic [BW_W-1:0]     bw_reg;
    logic                ktype_reg;
    logic [31:0]         u_reg;
    logic [WEIGHT_W-1:0] w_reg;
    logic                conn_reg;
    logic                last_reg;
    logic [31:0]         q_reg;
    logic [32:0]         f_reg;
    logic [KERN_W-1:0]   k_reg;
    logic [SUM_W-1:0]    num_reg, num_next;
    logic [SUM_W-1:0]    den_reg, den_next;
    logic                out_valid_reg;
    logic [RATIO_W-1:0]  ratio_reg;
    logic                empty_reg;
    div_op_t             op_reg;

    logic [SUM_W-1:0] div_rem, div_dvd, div_dvs, div_quo;
    logic [CNT_W-1:0] div_cnt;
    logic             div_done;
    logic [63:0]      q_sq;
    logic [33:0]      three_f;
    logic [SUM_W:0]   den_sum, num_sum;

    kce_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start),
        .rem_init (div_rem),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .count    (div_cnt),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        q_sq    = 64'(q_reg) * 64'(q_reg);
        three_f = 34'({1'b0, f_reg} + {f_reg, 1'b0});
        unique case (cmd.op)
            OP_Q:
            begin
                div_rem = SUM_W'(u_reg);
                div_dvd = '0;
                div_dvs = SUM_W'(bw_reg);
                div_cnt = CNT_W'(32);
            end
            OP_BOX:
            begin
                div_rem = '0;
                div_dvd = {1'b1, {(SUM_W-1){1'b0}}};
                div_dvs = SUM_W'(bw_reg);
                div_cnt = CNT_W'(48);
            end
            OP_K:
            begin
                div_rem = '0;
                div_dvd = {three_f, 30'b0};
                div_dvs = SUM_W'(bw_reg);
                div_cnt = CNT_W'(48);
            end
            OP_TERM:
            begin
                div_rem = '0;
                div_dvd = {k_reg, 16'b0};
                div_dvs = SUM_W'(w_reg[WEIGHT_W-2:0]);
                div_cnt = CNT_W'(64);
            end
            OP_RATIO:
            begin
                div_rem = num_reg;
                div_dvd = '0;
                div_dvs = den_reg;
                div_cnt = CNT_W'(16);
            end
            default:
            begin
                div_rem = '0;
                div_dvd = '0;
                div_dvs = '0;
                div_cnt = '0;
            end
        endcase

        // Saturating accumulation of the finished term.
        den_sum  = {1'b0, den_reg} + {1'b0, div_quo};
        num_sum  = {1'b0, num_reg} + {1'b0, div_quo};
        den_next = den_sum[SUM_W] ? {SUM_W{1'b1}} : den_sum[SUM_W-1:0];
        num_next = !conn_reg ? num_reg
                 : (num_sum[SUM_W] ? {SUM_W{1'b1}} : num_sum[SUM_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_reg        <= BW_RESET;
            ktype_reg     <= KTYPE_RESET;
            num_reg       <= '0;
            den_reg       <= '0;
            out_valid_reg <= 1'b0;
            op_reg        <= OP_Q;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BANDWIDTH:   bw_reg    <= cfg_data;
                    CFG_KERNEL_TYPE: ktype_reg <= cfg_data[0];
                    default:         bw_reg    <= bw_reg;
                endcase
            end
            if (cmd.start)
                op_reg <= cmd.op;
            if (div_done && op_reg == OP_TERM)
            begin
                den_reg <= den_next;
                num_reg <= num_next;
            end
            if (cmd.emit_empty || cmd.emit_one || (div_done && op_reg == OP_RATIO))
            begin
                out_valid_reg <= 1'b1;
                num_reg       <= '0;
                den_reg       <= '0;
            end
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            u_reg    <= (radius >= distance) ? radius - distance : distance - radius;
            w_reg    <= weight;
            conn_reg <= connected;
            last_reg <= last_pair;
        end
        if (cmd.mul)
            f_reg <= 33'h1_0000_0000 - {1'b0, q_sq[63:32]};
        if (div_done)
        begin
            unique case (op_reg)
                OP_Q:     q_reg <= div_quo[31:0];
                OP_BOX:   k_reg <= div_quo[KERN_W-1:0];
                OP_K:     k_reg <= div_quo[KERN_W-1:0];
                OP_RATIO:
                begin
                    ratio_reg <= div_quo[RATIO_W-1:0];
                    empty_reg <= 1'b0;
                end
                default:  k_reg <= k_reg;
            endcase
        end
        if (cmd.emit_empty)
        begin
            ratio_reg <= '0;
            empty_reg <= 1'b1;
        end
        if (cmd.emit_one)
        begin
            ratio_reg <= RATIO_ONE;
            empty_reg <= 1'b0;
        end
    end

    always_comb
    begin
        stat.skip       = w_reg[WEIGHT_W-1] || (w_reg[WEIGHT_W-2:0] == '0)
                       || (bw_reg == '0) || (u_reg >= bw_reg);
        stat.epan       = ktype_reg;
        stat.div_done   = div_done;
        stat.last       = last_reg;
        stat.den_zero   = (den_reg == '0);
        stat.num_eq_den = (num_reg == den_reg);
        stat.out_busy   = out_valid_reg && !out_ready;
    end

    assign out_valid = out_valid_reg;
    assign ratio     = ratio_reg;
    assign empty_sum = empty_reg;

endmodule

// File: rtl/kce_ctrl.sv
// Controller state machine sequencing the divider steps for each pair.
module kce_ctrl
    import kce_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  kce_stat_t stat,
    output kce_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIV_Q,
        S_MUL,
        S_START_K,
        S_DIV_K,
        S_START_T,
        S_DIV_T,
        S_END,
        S_DIV_R
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd.load       = 1'b0;
        cmd.start      = 1'b0;
        cmd.op         = OP_Q;
        cmd.mul        = 1'b0;
        cmd.emit_empty = 1'b0;
        cmd.emit_one   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority if (stat.skip)
                    state_next = S_END;
                else if (stat.epan)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_Q;
                    state_next = S_DIV_Q;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_BOX;
                    state_next = S_DIV_K;
                end
            end
            S_DIV_Q:
                if (stat.div_done)
                    state_next = S_MUL;
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_START_K;
            end
            S_START_K:
            begin
                cmd.start  = 1'b1;
                cmd.op     = OP_K;
                state_next = S_DIV_K;
            end
            S_DIV_K:
                if (stat.div_done)
                    state_next = S_START_T;
            S_START_T:
            begin
                cmd.start  = 1'b1;
                cmd.op     = OP_TERM;
                state_next = S_DIV_T;
            end
            S_DIV_T:
                if (stat.div_done)
                    state_next = S_END;
            S_END:
            begin
                priority if (!stat.last)
                    state_next = S_IDLE;
                else if (stat.out_busy)
                    state_next = S_END;
                else if (stat.den_zero)
                begin
                    cmd.emit_empty = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (stat.num_eq_den)
                begin
                    cmd.emit_one = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_RATIO;
                    state_next = S_DIV_R;
                end
            end
            S_DIV_R:
                if (stat.div_done)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// File: rtl/kernel_connectivity_estimate_unit.sv
// Top level of the kernel-smoothed connectivity estimate unit.
//
// The in_ch channel takes one point-pair word per handshake: radius, distance,
// connected, weight and last_pair. The out_ch channel delivers one word with
// ratio and empty_sum for every pair word marked last_pair; other pairs give none.
// The cfg port writes bandwidth (index 0) and kernel_type (index 1) on any
// clock edge with cfg_we high; the user must use it only while the unit is
// idle, as the unit itself does not enforce this. One pair word is processed
// at a time on a single shared one-bit-per-cycle divider. A skipped pair
// runs no division, a box-kernel pair runs the box and term divisions, and
// an Epanechnikov pair runs the offset division, the multiply, the kernel
// division and the term division. A last pair adds the ratio division
// unless the sum is empty or the ratio is one. The result register
// decouples the output: the next pair word is accepted while a result still
// waits, and only a following last pair stalls until the receiver takes the
// old one. Reset clears both sums, the result valid flag and the controller,
// and restores bandwidth to 1.0 and the box kernel.
module kernel_connectivity_estimate_unit
    import kce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    kce_in_if.sink      in_ch,
    kce_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    kce_cmd_t  cmd;
    kce_stat_t stat;

    kce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kce_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .radius    (in_ch.radius),
        .distance  (in_ch.distance),
        .connected (in_ch.connected),
        .weight    (in_ch.weight),
        .last_pair (in_ch.last_pair),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .ratio     (out_ch.ratio),
        .empty_sum (out_ch.empty_sum),
        .cmd       (cmd),
        .stat      (stat)
    );

    // The ratio never exceeds 1.0 in Q1.16.
    a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.ratio <= RATIO_ONE))
        else $error("ratio above 1.0");

    // An empty pass always reports a zero ratio.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.empty_sum) |-> (out_ch.ratio == '0))
        else $error("empty pass with nonzero ratio");

    // After a word is taken the unit is not ready in the cycle after.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("second word accepted back to back");

    // A new result is never loaded on top of one still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_empty || cmd.emit_one) |-> !(out_ch.valid && !out_ch.ready))
        else $error("result overwritten");

endmodule

// File: bench/kce_tb_pkg.sv
// Bench-side types for the kernel connectivity estimate unit testbench.
package kce_tb_pkg;

    // One point-pair word as driven onto the input channel.
    typedef struct {
        logic [31:0]        radius;
        logic [31:0]        distance;
        logic               connected;
        logic signed [47:0] weight;
        logic               last_pair;
    } pair_word_t;

    // One expected ratio word.
    typedef struct {
        logic [16:0] ratio;
        logic        empty_sum;
    } ratio_word_t;

endpackage

// File: bench/tb_kernel_connectivity_estimate_unit.sv
// Testbench of the kernel connectivity estimate unit with its own ratio predictor.
module tb_kernel_connectivity_estimate_unit;
    import kce_pkg::*;
    import kce_tb_pkg::*;

    // A pass in the directed table either carries a typed-in expected ratio word,
    // or it is left to the predictor.
    typedef struct {
        pair_word_t  pair;
        logic        typed;
        ratio_word_t typed_word;
    } pair_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [31:0] cfg_data;

    kce_in_if  in_ch ();
    kce_out_if out_ch ();

    kernel_connectivity_estimate_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: its own copy of the registers and both sums.
    logic [31:0] model_bandwidth;
    logic        model_epan;
    logic [63:0] conn_sum;
    logic [63:0] total_sum;

    ratio_word_t pending_ratios[$];
    int          error_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Hard stop: the timeout sits well above the slowest correct run of about 750
    // words with generous sender and receiver stalls.
    initial
    begin
        #40000000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic logic [63:0] add_saturated(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    // Kernel value in unsigned Q32.32 for offset u from the evaluation radius.
    function automatic logic [63:0] kernel_value(input logic [31:0] u);
        logic [63:0]  frac;
        logic [127:0] sq;
        logic [63:0]  rest;
        if (model_bandwidth == 32'd0 || u >= model_bandwidth)
            return 64'd0;
        if (!model_epan)
            return (64'd1 << 47) / {32'd0, model_bandwidth};
        frac = {u, 32'd0} / {32'd0, model_bandwidth};
        sq   = frac * frac;
        rest = (64'd1 << 32) - (sq >> 32);
        return ((64'd3 * rest) << 14) / {32'd0, model_bandwidth};
    endfunction

    // Accumulates one pair and returns 1 with the ratio word on a last pair.
    function automatic logic predict_ratio(input pair_word_t p, output ratio_word_t r);
        logic [31:0]  u;
        logic [63:0]  term;
        logic [127:0] q;
        r.ratio = '0;
        r.empty_sum = 1'b0;
        if (!p.weight[47] && p.weight[46:0] != 47'd0)
        begin
            u = (p.radius >= p.distance) ? p.radius - p.distance : p.distance - p.radius;
            term = (kernel_value(u) << 16) / {17'd0, p.weight[46:0]};
            total_sum = add_saturated(total_sum, term);
            if (p.connected)
                conn_sum = add_saturated(conn_sum, term);
        end
        if (!p.last_pair)
            return 1'b0;
        if (total_sum == 64'd0)
        begin
            r.empty_sum = 1'b1;
        end
        else
        begin
            q = {conn_sum, 16'd0} / {64'd0, total_sum};
            r.ratio = (q > 128'd65536) ? RATIO_ONE : q[16:0];
        end
        conn_sum  = '0;
        total_sum = '0;
        return 1'b1;
    endfunction

    // Drives one pair word and waits for its handshake, idling at random before it.
    // Valid stays high into the cycle after the handshake, when the unit is busy;
    // the caller or the next call takes it down.
    task automatic send_pair(input pair_word_t p);
        ratio_word_t r;
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.radius    <= p.radius;
        in_ch.distance  <= p.distance;
        in_ch.connected <= p.connected;
        in_ch.weight    <= p.weight;
        in_ch.last_pair <= p.last_pair;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (predict_ratio(p, r))
            pending_ratios.push_back(r);
        @(negedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [31:0] value);
        in_ch.valid <= 1'b0;
        // Let a trailing skipped or non-last pair drain before the write.
        while (pending_ratios.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_BANDWIDTH)
            model_bandwidth = value;
        else
            model_epan = value[0];
    endtask

    function automatic pair_word_t random_pair(input int pass_len_left);
        pair_word_t p;
        int sel;
        sel = $urandom_range(9, 0);
        p.radius    = $urandom();
        // Most distances lie close to the radius so that the kernel is nonzero.
        if (sel < 7)
            p.distance = p.radius + ($urandom() % (model_bandwidth + 32'd4)) -
                         (model_bandwidth >> 1);
        else
            p.distance = $urandom();
        p.connected = 1'($urandom_range(1, 0));
        case ($urandom_range(5, 0))
            0:       p.weight = -$signed({16'd0, $urandom()});
            1:       p.weight = {1'b0, 15'($urandom()), $urandom()};
            2:       p.weight = 48'd1;
            default: p.weight = {16'd0, $urandom_range(32'h0004_0000, 32'h0000_8000)};
        endcase
        p.last_pair = (pass_len_left == 0);
        return p;
    endfunction

    // Checker: samples the output channel at every rising edge.
    always @(posedge clk)
    begin
        ratio_word_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_ratios.size() == 0)
            begin
                report_mismatch("unexpected ratio word", 32'(out_ch.ratio), 32'd0);
            end
            else
            begin
                want = pending_ratios.pop_front();
                if (out_ch.ratio !== want.ratio)
                    report_mismatch("ratio", 32'(out_ch.ratio), 32'(want.ratio));
                if (out_ch.empty_sum !== want.empty_sum)
                    report_mismatch("empty_sum", 32'(out_ch.empty_sum),
                                    32'(want.empty_sum));
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off requested by hold_cycles.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
            end
        end
    end

    initial
    begin
        pair_row_t   rows[$];
        pair_row_t   row;
        ratio_word_t r;
        ratio_word_t empty_word;
        int          phase;
        int          left;
        int          drain;

        error_count   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_BANDWIDTH;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.radius  = '0;
        in_ch.distance = '0;
        in_ch.connected = 1'b0;
        in_ch.weight  = '0;
        in_ch.last_pair = 1'b0;
        model_bandwidth = BW_RESET;
        model_epan    = KTYPE_RESET;
        conn_sum      = '0;
        total_sum     = '0;
        empty_word.ratio = '0;
        empty_word.empty_sum = 1'b1;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed table. Typed rows are passes that read off at a glance.
        // An empty pass right after reset gives the empty flag.
        rows.push_back('{'{32'h0, 32'h0, 1'b0, 48'sd0, 1'b1}, 1'b1, empty_word});
        // A negative weight skips the pair.
        rows.push_back('{'{32'h1_0000, 32'h1_0000, 1'b1, -48'sd65536, 1'b1}, 1'b1,
                         empty_word});
        // Most negative weight, also skipped.
        rows.push_back('{'{32'hFFFF_FFFF, 32'h0, 1'b1, 48'sh8000_0000_0000, 1'b1},
                         1'b1, empty_word});
        // Offset beyond the bandwidth gives a zero kernel.
        rows.push_back('{'{32'hFFFF_FFFF, 32'h0, 1'b1, 48'sd65536, 1'b1}, 1'b1,
                         empty_word});
        // One connected pair alone gives the full ratio.
        rows.push_back('{'{32'h1_0000, 32'h1_0000, 1'b1, 48'sd65536, 1'b1}, 1'b1,
                         '{RATIO_ONE, 1'b0}});
        // One unconnected pair alone gives zero without the empty flag.
        rows.push_back('{'{32'h1_0000, 32'h1_0000, 1'b0, 48'sd65536, 1'b1}, 1'b1,
                         '{17'd0, 1'b0}});
        // Half connected, with a largest positive weight that adds a term of one.
        rows.push_back('{'{32'h2_0000, 32'h2_0000, 1'b1, 48'sd65536, 1'b0}, 1'b0,
                         empty_word});
        rows.push_back('{'{32'h2_0000, 32'h2_8000, 1'b0, 48'sd65536, 1'b0}, 1'b0,
                         empty_word});
        rows.push_back('{'{32'h0, 32'h0, 1'b1, 48'sh7FFF_FFFF_FFFF, 1'b1}, 1'b0,
                         empty_word});
        // Smallest weight: a huge term per pair pushes toward saturation.
        rows.push_back('{'{32'h0, 32'h0, 1'b1, 48'sd1, 1'b0}, 1'b0, empty_word});
        rows.push_back('{'{32'h0, 32'h0, 1'b0, 48'sd1, 1'b0}, 1'b0, empty_word});
        rows.push_back('{'{32'h0, 32'h8000, 1'b1, 48'sd1, 1'b1}, 1'b0, empty_word});

        foreach (rows[i])
        begin
            row = rows[i];
            if (row.typed)
                // Typed rows all end a pass that starts from clear sums.
                void'(predict_ratio(row.pair, r));
            send_pair(row.pair);
            if (row.typed)
            begin
                // The predictor queued its own word; replace it with the typed one.
                while (pending_ratios.size() == 0)
                    @(negedge clk);
                void'(pending_ratios.pop_back());
                pending_ratios.push_back(row.typed_word);
            end
        end

        // The typed rows above ran the predictor twice; the extra pass had no
        // last pair effect on the sums since both passes ended with a clear.
        // Epanechnikov kernel at a small and the largest bandwidth, then a zero one and the smallest nonzero one.
        write_register(CFG_KERNEL_TYPE, 32'd1);
        send_pair('{32'h1_0000, 32'h1_4000, 1'b1, 48'sd65536, 1'b0});
        send_pair('{32'h1_0000, 32'h0_C000, 1'b0, 48'sd131072, 1'b1});
        write_register(CFG_BANDWIDTH, 32'hFFFF_FFFF);
        send_pair('{32'h0, 32'hFFFF_FFFE, 1'b1, 48'sd65536, 1'b0});
        send_pair('{32'h8000_0000, 32'h0, 1'b0, 48'sd3, 1'b1});
        write_register(CFG_BANDWIDTH, 32'd0);
        send_pair('{32'h0, 32'h0, 1'b1, 48'sd65536, 1'b1});
        write_register(CFG_BANDWIDTH, 32'd1);
        send_pair('{32'h5, 32'h5, 1'b1, 48'sd1, 1'b1});

        // Random passes in three idling phases, each with its own settings.
        for (phase = 0; phase < 3; phase++)
        begin
            write_register(CFG_KERNEL_TYPE, 32'(phase != 1));
            write_register(CFG_BANDWIDTH,
                           (phase == 2) ? 32'hFFFF_FFFF : $urandom_range(32'h4_0000, 32'h100));
            send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 69 : 0;
            recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 21 : 0;
            if (phase == 2)
                hold_cycles = 3000;
            left = $urandom_range(8, 0);
            for (int n = 0; n < 245; n++)
            begin
                send_pair(random_pair(left));
                left = (left == 0) ? $urandom_range(8, 0) : left - 1;
            end
            // Close any open pass so the register writes come at idle.
            send_pair(random_pair(0));
        end
        in_ch.valid <= 1'b0;

        drain = 0;
        while (pending_ratios.size() != 0 && drain < 200000)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (200) @(negedge clk);
        if (error_count == 0 && pending_ratios.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
